@@ hw/rtl/brs_pkg.sv @@
package brs_pkg;

   localparam int IDX_W = 12;
   localparam int VAL_W = 32;
   localparam int SUM_W = 44;
   localparam int PTR_W = IDX_W + 1;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_CLEAR     = 3'd0;
   localparam logic [ST_W-1:0] ST_IDLE      = 3'd1;
   localparam logic [ST_W-1:0] ST_UPD_WRITE = 3'd2;
   localparam logic [ST_W-1:0] ST_QUERY     = 3'd3;
   localparam logic [ST_W-1:0] ST_DRAIN     = 3'd4;
   localparam logic [ST_W-1:0] ST_DONE      = 3'd5;

   typedef logic [SUM_W-1:0] sum_type;

endpackage

@@ hw/rtl/brs_ram.sv @@
module brs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/block_decomposed_range_sum.sv @@
// update: accepted in IDLE, store written in the next cycle; req_stall holds off the next beat until then
// query: one store read per cycle, a whole block through its stored total,
//   at most 2*BLOCK + NUM_BLOCKS reads, then the DRAIN and DONE states before output
// result held in an output register while the next request is taken
// reset: a clearing pass zeroes every address of both stores,
//   req_stall stays high until it ends
module block_decomposed_range_sum #(
   parameter int DEPTH      = 4096,
   parameter int BLOCK      = 64,
   parameter int NUM_BLOCKS = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_opcode,
   input  logic [brs_pkg::IDX_W-1:0]              req_first_index,
   input  logic [brs_pkg::IDX_W-1:0]              req_last_index,
   input  logic signed [brs_pkg::VAL_W-1:0]       req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [brs_pkg::SUM_W-1:0]       rsp_range_total,
   output logic                                   rsp_bad_range
);

   localparam int AW    = $clog2(DEPTH);
   localparam int BAW   = $clog2(NUM_BLOCKS);
   localparam int LB    = $clog2(BLOCK);
   localparam int TOT_W = brs_pkg::VAL_W + LB;
   localparam int CLR_N = (DEPTH > NUM_BLOCKS) ? DEPTH : NUM_BLOCKS;
   localparam int CLW   = $clog2(CLR_N);
   localparam logic [brs_pkg::PTR_W-1:0] LAST_CAP =
      (DEPTH >= (1 << brs_pkg::IDX_W)) ? brs_pkg::PTR_W'((1 << brs_pkg::IDX_W) - 1)
                                       : brs_pkg::PTR_W'(DEPTH - 1);
   localparam logic [brs_pkg::PTR_W-1:0] BLK_SPAN = brs_pkg::PTR_W'(BLOCK - 1);
   localparam logic [brs_pkg::PTR_W-1:0] BLK_STEP = brs_pkg::PTR_W'(BLOCK);
   localparam logic [brs_pkg::PTR_W-1:0] NB_LIM   = brs_pkg::PTR_W'(NUM_BLOCKS);

   logic [brs_pkg::ST_W-1:0]      state_ff, state_in;
   logic [CLW-1:0]                clr_ff, clr_in;
   logic [brs_pkg::PTR_W-1:0]     ptr_ff, ptr_in;
   logic [brs_pkg::PTR_W-1:0]     hi_ff, hi_in;
   logic signed [brs_pkg::VAL_W-1:0] val_ff, val_in;
   logic                          tot_ok_ff, tot_ok_in;
   brs_pkg::sum_type              acc_ff, acc_in;
   logic                          bad_ff, bad_in;
   logic                          rd_elem_ff, rd_elem_in;
   logic                          rd_tot_ff, rd_tot_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   brs_pkg::sum_type              rsp_total_ff, rsp_total_in;
   logic                          rsp_bad_ff, rsp_bad_in;

   logic                          elem_wr_en, elem_rd_en;
   logic [AW-1:0]                 elem_wr_addr, elem_rd_addr;
   logic [brs_pkg::VAL_W-1:0]     elem_wr_data, elem_rd_data;
   logic                          tot_wr_en, tot_rd_en;
   logic [BAW-1:0]                tot_wr_addr, tot_rd_addr;
   logic [TOT_W-1:0]              tot_wr_data, tot_rd_data;

   logic [brs_pkg::PTR_W-1:0]     first_ext, last_ext, req_blk, ptr_blk, ptr_next;
   logic                          whole_blk;
   brs_pkg::sum_type              addend;
   logic                          out_free;

   brs_ram #(.WIDTH(brs_pkg::VAL_W), .DEPTH(DEPTH)) u_elem_ram (
      .clock   (clock),
      .wr_en   (elem_wr_en),
      .wr_addr (elem_wr_addr),
      .wr_data (elem_wr_data),
      .rd_en   (elem_rd_en),
      .rd_addr (elem_rd_addr),
      .rd_data (elem_rd_data)
   );

   brs_ram #(.WIDTH(TOT_W), .DEPTH(NUM_BLOCKS)) u_tot_ram (
      .clock   (clock),
      .wr_en   (tot_wr_en),
      .wr_addr (tot_wr_addr),
      .wr_data (tot_wr_data),
      .rd_en   (tot_rd_en),
      .rd_addr (tot_rd_addr),
      .rd_data (tot_rd_data)
   );

   assign first_ext = brs_pkg::PTR_W'(req_first_index);
   assign last_ext  = brs_pkg::PTR_W'(req_last_index);
   assign req_blk   = first_ext >> LB;
   assign ptr_blk   = ptr_ff >> LB;
   assign whole_blk = (ptr_ff[LB-1:0] == '0) && ((ptr_ff + BLK_SPAN) <= hi_ff) &&
                      (ptr_blk < NB_LIM);
   assign ptr_next  = whole_blk ? (ptr_ff + BLK_STEP) : (ptr_ff + 1'b1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      addend = '0;
      if (rd_elem_ff) begin
         addend = brs_pkg::SUM_W'($signed(elem_rd_data));
      end else if (rd_tot_ff) begin
         addend = brs_pkg::SUM_W'($signed(tot_rd_data));
      end
   end

   // memory ports
   always_comb begin
      elem_rd_en   = 1'b0;
      tot_rd_en    = 1'b0;
      elem_rd_addr = AW'(ptr_ff);
      tot_rd_addr  = BAW'(ptr_blk);
      if (state_ff == brs_pkg::ST_IDLE) begin
         elem_rd_en   = req_valid && (req_opcode == brs_pkg::OP_UPDATE);
         tot_rd_en    = req_valid && (req_opcode == brs_pkg::OP_UPDATE);
         elem_rd_addr = AW'(first_ext);
         tot_rd_addr  = BAW'(req_blk);
      end else if (state_ff == brs_pkg::ST_QUERY) begin
         elem_rd_en = !whole_blk;
         tot_rd_en  = whole_blk;
      end
   end

   always_comb begin
      elem_wr_en   = 1'b0;
      tot_wr_en    = 1'b0;
      elem_wr_addr = AW'(ptr_ff);
      tot_wr_addr  = BAW'(ptr_blk);
      elem_wr_data = val_ff;
      tot_wr_data  = tot_rd_data + TOT_W'(val_ff) - TOT_W'($signed(elem_rd_data));
      if (state_ff == brs_pkg::ST_CLEAR) begin
         elem_wr_en   = int'(clr_ff) < DEPTH;
         tot_wr_en    = int'(clr_ff) < NUM_BLOCKS;
         elem_wr_addr = AW'(clr_ff);
         tot_wr_addr  = BAW'(clr_ff);
         elem_wr_data = '0;
         tot_wr_data  = '0;
      end else if (state_ff == brs_pkg::ST_UPD_WRITE) begin
         elem_wr_en = 1'b1;
         tot_wr_en  = tot_ok_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      ptr_in       = ptr_ff;
      hi_in        = hi_ff;
      val_in       = val_ff;
      tot_ok_in    = tot_ok_ff;
      acc_in       = acc_ff + addend;
      bad_in       = bad_ff;
      rd_elem_in   = 1'b0;
      rd_tot_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_total_in = rsp_total_ff;
      rsp_bad_in   = rsp_bad_ff;
      req_stall    = state_ff != brs_pkg::ST_IDLE;
      unique case (state_ff)
         brs_pkg::ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLW'(CLR_N - 1)) begin
               state_in = brs_pkg::ST_IDLE;
            end
         end
         brs_pkg::ST_IDLE: begin
            acc_in = '0;
            bad_in = 1'b0;
            if (req_valid) begin
               if (req_opcode == brs_pkg::OP_UPDATE) begin
                  ptr_in    = first_ext;
                  val_in    = req_value;
                  tot_ok_in = req_blk < NB_LIM;
                  if (first_ext <= LAST_CAP) begin
                     state_in = brs_pkg::ST_UPD_WRITE;
                  end
               end else if (req_first_index > req_last_index) begin
                  bad_in   = 1'b1;
                  state_in = brs_pkg::ST_DONE;
               end else if (first_ext > LAST_CAP) begin
                  state_in = brs_pkg::ST_DONE;
               end else begin
                  ptr_in   = first_ext;
                  hi_in    = (last_ext > LAST_CAP) ? LAST_CAP : last_ext;
                  state_in = brs_pkg::ST_QUERY;
               end
            end
         end
         brs_pkg::ST_UPD_WRITE: begin
            state_in = brs_pkg::ST_IDLE;
         end
         brs_pkg::ST_QUERY: begin
            rd_elem_in = !whole_blk;
            rd_tot_in  = whole_blk;
            ptr_in     = ptr_next;
            if (ptr_next > hi_ff) begin
               state_in = brs_pkg::ST_DRAIN;
            end
         end
         brs_pkg::ST_DRAIN: begin
            state_in = brs_pkg::ST_DONE;
         end
         brs_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_total_in = acc_ff;
               rsp_bad_in   = bad_ff;
               state_in     = brs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = brs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brs_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rd_elem_ff   <= 1'b0;
         rd_tot_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rd_elem_ff   <= rd_elem_in;
         rd_tot_ff    <= rd_tot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      hi_ff        <= hi_in;
      val_ff       <= val_in;
      tot_ok_ff    <= tot_ok_in;
      acc_ff       <= acc_in;
      bad_ff       <= bad_in;
      rsp_total_ff <= rsp_total_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_range_total = rsp_total_ff;
   assign rsp_bad_range   = rsp_bad_ff;

endmodule

@@ tb/tb_block_decomposed_range_sum.sv @@
module tb_block_decomposed_range_sum;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH      = 4096;
   localparam int BLOCK      = 64;
   localparam int NUM_BLOCKS = 64;
   localparam int BLK_W      = brs_pkg::VAL_W + $clog2(BLOCK);
   localparam logic signed [brs_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
   localparam logic signed [brs_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam int TAIL_CYCLES = 2 * BLOCK + NUM_BLOCKS + 64;

   typedef struct {
      logic signed [brs_pkg::SUM_W-1:0] total;
      logic                             bad;
   } range_result_type;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic                             req_opcode;
   logic [brs_pkg::IDX_W-1:0]        req_first_index;
   logic [brs_pkg::IDX_W-1:0]        req_last_index;
   logic signed [brs_pkg::VAL_W-1:0] req_value;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic signed [brs_pkg::SUM_W-1:0] rsp_range_total;
   logic                             rsp_bad_range;

   logic signed [brs_pkg::VAL_W-1:0] elem_mem [DEPTH];
   logic signed [BLK_W-1:0]          blk_sum [NUM_BLOCKS];
   range_result_type                 pending_sums [$];
   range_result_type                 oldest;

   int error_count     = 0;
   int updates_sent    = 0;
   int queries_sent    = 0;
   int reversed_sent   = 0;
   int results_checked = 0;
   bit send_gaps       = 1'b0;
   bit rsp_gaps        = 1'b0;
   int rsp_hold        = 0;

   block_decomposed_range_sum #(
      .DEPTH      (DEPTH),
      .BLOCK      (BLOCK),
      .NUM_BLOCKS (NUM_BLOCKS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_first_index (req_first_index),
      .req_last_index  (req_last_index),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_range_total (rsp_range_total),
      .rsp_bad_range   (rsp_bad_range)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // predictor: model updates and expected range sums
   function automatic longint span_sum(input int lo_i, input int hi_i);
      longint acc;
      acc = 0;
      for (int i = lo_i; i <= hi_i && i < DEPTH; i++)
         acc += longint'(elem_mem[i]);
      return acc;
   endfunction

   function automatic void apply_update(input int idx,
                                        input logic signed [brs_pkg::VAL_W-1:0] v);
      int b;
      if (idx < DEPTH) begin
         b = idx / BLOCK;
         if (b < NUM_BLOCKS)
            blk_sum[b] = BLK_W'(longint'(blk_sum[b]) + longint'(v) - longint'(elem_mem[idx]));
         elem_mem[idx] = v;
      end
   endfunction

   function automatic range_result_type predict_range_sum(input int lo, input int hi);
      range_result_type r;
      longint           acc;
      int               lb;
      int               rb;
      acc = 0;
      r.bad = 1'b0;
      if (lo > hi) begin
         r.bad = 1'b1;
      end else if (lo < DEPTH) begin
         if (hi >= DEPTH)
            hi = DEPTH - 1;
         lb = lo / BLOCK;
         rb = hi / BLOCK;
         if (lb == rb) begin
            acc = span_sum(lo, hi);
         end else begin
            acc = span_sum(lo, (lb + 1) * BLOCK - 1) + span_sum(rb * BLOCK, hi);
            for (int b = lb + 1; b < rb; b++)
               acc += (b < NUM_BLOCKS) ? longint'(blk_sum[b])
                                       : span_sum(b * BLOCK, b * BLOCK + BLOCK - 1);
         end
      end
      r.total = acc[brs_pkg::SUM_W-1:0];
      return r;
   endfunction

   task automatic send_beat(input logic op, input logic [brs_pkg::IDX_W-1:0] fi,
                            input logic [brs_pkg::IDX_W-1:0] la,
                            input logic signed [brs_pkg::VAL_W-1:0] v);
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_first_index <= fi;
      req_last_index  <= la;
      req_value       <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == brs_pkg::OP_UPDATE) begin
         apply_update(int'(fi), v);
         updates_sent++;
      end else begin
         pending_sums.insert(pending_sums.size(), predict_range_sum(int'(fi), int'(la)));
         queries_sent++;
         if (fi > la)
            reversed_sent++;
      end
   endtask

   task automatic send_update(input int idx, input logic signed [brs_pkg::VAL_W-1:0] v);
      send_beat(brs_pkg::OP_UPDATE, brs_pkg::IDX_W'(idx), brs_pkg::IDX_W'($urandom), v);
   endtask

   task automatic send_query(input int lo, input int hi);
      send_beat(brs_pkg::OP_QUERY, brs_pkg::IDX_W'(lo), brs_pkg::IDX_W'(hi),
                brs_pkg::VAL_W'($urandom));
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_sums.size() != 0);
   endtask

   function automatic int pick_index();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return DEPTH - 1;
         2: return $urandom_range(0, NUM_BLOCKS - 1) * BLOCK
                   + ($urandom_range(0, 1) ? BLOCK - 1 : 0);
         default: return $urandom_range(0, DEPTH - 1);
      endcase
   endfunction

   function automatic logic signed [brs_pkg::VAL_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return VAL_MAX;
         1: return VAL_MIN;
         2: return brs_pkg::VAL_W'($urandom_range(0, 15)) - 8;
         default: return brs_pkg::VAL_W'($urandom);
      endcase
   endfunction

   task automatic random_query();
      int lo;
      int hi;
      int t;
      case ($urandom_range(0, 9))
         0: begin
            lo = $urandom_range(1, DEPTH - 1);
            hi = $urandom_range(0, lo - 1);
         end
         1: begin
            lo = pick_index();
            hi = lo;
         end
         2, 3: begin
            lo = $urandom_range(0, DEPTH - 1);
            hi = lo + $urandom_range(0, BLOCK - 1 - lo % BLOCK);
         end
         4, 5: begin
            lo = pick_index();
            hi = lo + $urandom_range(0, 5 * BLOCK);
            if (hi > DEPTH - 1)
               hi = DEPTH - 1;
         end
         6: begin
            lo = $urandom_range(0, BLOCK);
            hi = DEPTH - 1 - $urandom_range(0, BLOCK);
         end
         default: begin
            lo = pick_index();
            hi = pick_index();
            if (lo > hi) begin
               t  = lo;
               lo = hi;
               hi = t;
            end
         end
      endcase
      send_query(lo, hi);
   endtask

   task automatic random_beat();
      if ($urandom_range(0, 99) < 45)
         send_update(pick_index(), pick_value());
      else
         random_query();
   endtask

   // result side: random stall bursts plus a long hold when asked
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (rsp_gaps && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(1, 7) - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_sums.size() == 0) begin
            report_mismatch("result beat with no query pending");
         end else begin
            oldest = pending_sums.pop_front();
            if (rsp_range_total !== oldest.total)
               report_mismatch($sformatf("result %0d range_total got %0d want %0d",
                                         results_checked, rsp_range_total, oldest.total));
            if (rsp_bad_range !== oldest.bad)
               report_mismatch($sformatf("result %0d bad_range got %b want %b",
                                         results_checked, rsp_bad_range, oldest.bad));
         end
         results_checked++;
      end
   end

   task automatic test_directed_extremes();
      send_query(0, DEPTH - 1);
      send_update(0, VAL_MAX);
      send_update(DEPTH - 1, VAL_MIN);
      send_update(BLOCK - 1, VAL_MAX);
      send_update(BLOCK, VAL_MAX);
      send_update(BLOCK, -5);
      send_update(2000, 32'sh5a5a_5a5a);
      send_update(2001, 32'sha5a5_a5a5);
      send_query(0, 0);
      send_query(DEPTH - 1, DEPTH - 1);
      send_query(BLOCK - 1, BLOCK);
      send_query(0, BLOCK - 1);
      send_query(1, DEPTH - 2);
      send_query(0, DEPTH - 1);
      send_query(5, 4);
      send_query(DEPTH - 1, 0);
      send_query(100, 2001);
      send_update(DEPTH - 1, 0);
      send_query(DEPTH - BLOCK, DEPTH - 1);
      send_update(0, 0);
      send_query(0, BLOCK);
   endtask

   task automatic test_random_mix(input int count);
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) begin
            send_gaps = $urandom_range(0, 2) != 0;
            rsp_gaps  = $urandom_range(0, 2) != 0;
         end
         random_beat();
      end
   endtask

   task automatic test_output_backpressure();
      rsp_hold = 400;
      send_gaps = 1'b0;
      for (int n = 0; n < 12; n++)
         send_query($urandom_range(0, BLOCK - 1), $urandom_range(BLOCK, 3 * BLOCK));
      for (int n = 0; n < 8; n++)
         random_beat();
      wait_all_results();
   endtask

   task automatic test_drain_pause();
      send_gaps = 1'b1;
      rsp_gaps  = 1'b1;
      for (int n = 0; n < 20; n++)
         random_beat();
      wait_all_results();
      for (int n = 0; n < 20; n++)
         random_beat();
   endtask

   task automatic test_steady_stream(input int count);
      send_gaps = 1'b0;
      rsp_gaps  = 1'b0;
      for (int n = 0; n < count; n++)
         random_beat();
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++)
         elem_mem[i] = '0;
      for (int b = 0; b < NUM_BLOCKS; b++)
         blk_sum[b] = '0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_opcode      <= brs_pkg::OP_UPDATE;
      req_first_index <= '0;
      req_last_index  <= '0;
      req_value       <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_extremes();
      test_random_mix(300);
      test_output_backpressure();
      test_drain_pause();
      test_steady_stream(120);

      wait_all_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d updates and %0d range queries (%0d reversed), %0d results checked",
               updates_sent, queries_sent, reversed_sent, results_checked);
      $display("with random idling on both sides, a long result hold-off and a drain pause");
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ block_decomposed_range_sum.f @@
hw/rtl/brs_pkg.sv
hw/rtl/brs_ram.sv
hw/rtl/block_decomposed_range_sum.sv
tb/tb_block_decomposed_range_sum.sv
